### rtl/core/assert_macros.svh
// Assertion helpers shared by the core modules.
// Every use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define GAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/gar_pkg.sv
package gar_pkg;

  localparam int DIM_BITS        = 12;
  localparam int WORD_BITS       = 21;
  localparam int ALPHA_BITS      = 8;
  localparam int CODE_BITS       = 8;
  localparam int GLYPH_COLS      = 5;
  localparam int GLYPH_ROWS      = 7;
  localparam int GLYPH_BITS      = GLYPH_COLS * GLYPH_ROWS;
  localparam int GLYPH_COUNT     = 95;
  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int RES_DATA_BITS   = WORD_BITS + 1 + ALPHA_BITS;
  localparam int OUT_DATA_BITS   = ((RES_DATA_BITS + 7) / 8) * 8;
  localparam int CFG_ADDR_BITS   = 4;

  localparam logic [CODE_BITS-1:0] GLYPH_FIRST = 8'd32;
  localparam logic [CODE_BITS-1:0] GLYPH_LAST  = 8'd126;

  localparam logic [1:0] REG_MIRROR = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_ALPHA  = 2'd3;

  localparam logic                  MIRROR_RST = 1'b1;
  localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 12'd1080;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 12'd720;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RST  = 8'hFF;

  typedef logic [DIM_BITS-1:0] dim_t;

  typedef struct packed {
    logic                  last;
    logic                  wr;
    logic                  buf_sel;
    logic [WORD_BITS-1:0]  word;
    logic                  lane;
    logic [ALPHA_BITS-1:0] alpha;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t rec;
  } push_t;

  // Five column bytes per glyph, column 0 in the top byte; bit r of a column is row r.
  localparam logic [39:0] FONT_ROM [0:GLYPH_COUNT-1] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  // Lit bits of a glyph, bit col*7+row; zero for codes that draw nothing.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [CODE_BITS-1:0] code);
    logic [39:0]           cols;
    logic [6:0]            idx;
    logic [GLYPH_BITS-1:0] m;
    int                    c;
    int                    r;
    cols = '0;
    idx  = 7'(code - GLYPH_FIRST);
    if (code >= GLYPH_FIRST && code <= GLYPH_LAST) begin
      cols = FONT_ROM[idx];
    end
    m = '0;
    for (c = 0; c < GLYPH_COLS; c++) begin
      for (r = 0; r < GLYPH_ROWS; r++) begin
        m[c*GLYPH_ROWS + r] = cols[32 - 8*c + r];
      end
    end
    return m;
  endfunction

endpackage

### rtl/core/glyph_alpha_rasterizer.sv
// 5x7 glyph rasterizer producing alpha writes for a 16-bit word buffer.
// in_*: one request per character; tdata holds char_code, pos_x, pos_y from
// bit 0 up, tuser holds buffer_select.
// out_*: one request per lit on-screen pixel; tdata holds word_index,
// byte_lane, alpha_value from bit 0 up, tuser holds write_valid, then
// target_buffer; tlast marks the final request of a character. A character
// with no visible pixel gives one request with write_valid low and tlast high.
// cfg_*: APB register port, registers at byte addresses 0, 4, 8, 12:
// mirror_x, disp_width, disp_height, text_alpha. pready is always high.
// Path: an accepted character goes through the PREP state, then the WALK state
// up to its first visible bit (none for a character with nothing visible),
// then the s1 and s2 registers, the queue RAM read and the output register.
// Throughput: the walker steps one glyph bit per cycle, stopping after the
// last visible bit; a new character waits until the walker, s1 and s2 are empty.
// Results go through a queue RAM of QUEUE_DEPTH entries; a new character is
// taken once the walker is idle and the queue has room for 35 results, so a
// stalled receiver stops input only once fewer than 35 entries are free.
// Reset: synchronous, active low; empties the queue and restores register
// defaults (mirror on, 1080 x 720, alpha 255).
module glyph_alpha_rasterizer #(
  parameter int COORD_BITS  = gar_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = gar_pkg::QUEUE_DEPTH_DEF,
  localparam int IN_DATA_BITS = ((gar_pkg::CODE_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_DATA_BITS-1:0]              in_tdata,    // char_code, pos_x, pos_y
  input  logic                                 in_tuser,    // buffer_select
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [gar_pkg::OUT_DATA_BITS-1:0]    out_tdata,   // word_index, byte_lane, alpha_value
  output logic [1:0]                           out_tuser,   // write_valid, target_buffer
  output logic                                 out_tlast,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [gar_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  import gar_pkg::*;

  logic                  mirror_r;
  dim_t                  width_r, height_r;
  logic [ALPHA_BITS-1:0] alpha_r;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;
  logic                  space_ok;
  push_t                 push;
  res_t                  out_rec;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= MIRROR_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      alpha_r  <= ALPHA_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIRROR: mirror_r <= cfg_pwdata[0];
        REG_WIDTH:  width_r  <= cfg_pwdata[DIM_BITS-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[DIM_BITS-1:0];
        REG_ALPHA:  alpha_r  <= cfg_pwdata[ALPHA_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIRROR: cfg_prdata = {31'b0, mirror_r};
      REG_WIDTH:  cfg_prdata = {{(32-DIM_BITS){1'b0}}, width_r};
      REG_HEIGHT: cfg_prdata = {{(32-DIM_BITS){1'b0}}, height_r};
      REG_ALPHA:  cfg_prdata = {{(32-ALPHA_BITS){1'b0}}, alpha_r};
    endcase
  end

  gar_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .char_code    (in_tdata[CODE_BITS-1:0]),
    .pos_x        ($signed(in_tdata[CODE_BITS +: COORD_BITS])),
    .pos_y        ($signed(in_tdata[CODE_BITS + COORD_BITS +: COORD_BITS])),
    .buffer_select(in_tuser),
    .space_ok     (space_ok),
    .mirror_x     (mirror_r),
    .disp_width   (width_r),
    .disp_height  (height_r),
    .text_alpha   (alpha_r),
    .push         (push)
  );

  gar_outq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_rec  (out_rec)
  );

  assign out_tdata = {{(OUT_DATA_BITS-RES_DATA_BITS){1'b0}},
                      out_rec.alpha, out_rec.lane, out_rec.word};
  assign out_tuser = {out_rec.buf_sel, out_rec.wr};
  assign out_tlast = out_rec.last;

endmodule

### rtl/core/gar_ram.sv
module gar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/gar_walker.sv
`include "assert_macros.svh"

module gar_walker #(
  parameter int COORD_BITS = gar_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gar_pkg::CODE_BITS-1:0]       char_code,
  input  logic signed [COORD_BITS-1:0]        pos_x,
  input  logic signed [COORD_BITS-1:0]        pos_y,
  input  logic                                buffer_select,
  input  logic                                space_ok,
  input  logic                                mirror_x,
  input  gar_pkg::dim_t                       disp_width,
  input  gar_pkg::dim_t                       disp_height,
  input  logic [gar_pkg::ALPHA_BITS-1:0]      text_alpha,
  output gar_pkg::push_t                      push
);

  import gar_pkg::*;

  localparam int XW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
  localparam int PW = 2 * DIM_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]                  st_r, st_nxt;
  logic [CODE_BITS-1:0]        code_r;
  logic signed [COORD_BITS-1:0] x0_r, y0_r;
  logic                        tbuf_r;
  logic [GLYPH_BITS-1:0]       mask_r, mask_nxt;
  dim_t                        xcol_r [GLYPH_COLS];
  logic [2:0]                  col_r, row_r;

  logic                        s1_v_r, s1_wr_r, s1_last_r, s1_buf_r;
  dim_t                        s1_x_r, s1_y_r;
  logic [ALPHA_BITS-1:0]       s1_alpha_r;

  logic                        s2_v_r, s2_wr_r, s2_last_r, s2_buf_r;
  logic [PW-1:0]               s2_prod_r;
  dim_t                        s2_x_r;
  logic [ALPHA_BITS-1:0]       s2_alpha_r;

  logic signed [XW-1:0]        wext, hext, x0_ext, y0_ext, xs, ys, walk_yw;
  logic signed [XW-1:0]        sx [GLYPH_COLS];
  logic [GLYPH_COLS-1:0]       col_ok;
  logic [GLYPH_ROWS-1:0]       row_ok;
  logic [GLYPH_BITS-1:0]       lit, prep_mask;

  logic                        s1_load, s1_wr_n, s1_last_n;
  dim_t                        s1_x_n, s1_y_n;
  logic [PW:0]                 pix;

  assign in_ready = (st_r == ST_IDLE) && !s1_v_r && !s2_v_r && space_ok;

  always_comb begin
    wext   = $signed({{(XW-DIM_BITS){1'b0}}, disp_width});
    hext   = $signed({{(XW-DIM_BITS){1'b0}}, disp_height});
    x0_ext = $signed({{(XW-COORD_BITS){x0_r[COORD_BITS-1]}}, x0_r});
    y0_ext = $signed({{(XW-COORD_BITS){y0_r[COORD_BITS-1]}}, y0_r});
    lit    = glyph_bits(code_r);
    xs     = '0;
    ys     = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      xs        = x0_ext + XW'(c);
      sx[c]     = mirror_x ? (wext - XW'(1) - xs) : xs;
      col_ok[c] = !sx[c][XW-1] && (sx[c] < wext);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      ys        = y0_ext + XW'(r);
      row_ok[r] = !ys[XW-1] && (ys < hext);
    end
    for (int c = 0; c < GLYPH_COLS; c++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        prep_mask[c*GLYPH_ROWS + r] = lit[c*GLYPH_ROWS + r] & col_ok[c] & row_ok[r];
      end
    end
    walk_yw = y0_ext + XW'(row_r);
  end

  always_comb begin
    st_nxt    = st_r;
    mask_nxt  = mask_r;
    s1_load   = 1'b0;
    s1_wr_n   = 1'b0;
    s1_last_n = 1'b0;
    s1_x_n    = '0;
    s1_y_n    = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          st_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        mask_nxt = prep_mask;
        if (prep_mask == '0) begin
          s1_load   = 1'b1;
          s1_last_n = 1'b1;
          st_nxt    = ST_IDLE;
        end else begin
          st_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        mask_nxt = mask_r >> 1;
        if (mask_r[0]) begin
          s1_load   = 1'b1;
          s1_wr_n   = 1'b1;
          s1_last_n = (mask_r[GLYPH_BITS-1:1] == '0);
          s1_x_n    = xcol_r[col_r];
          s1_y_n    = walk_yw[DIM_BITS-1:0];
        end
        if (mask_r[GLYPH_BITS-1:1] == '0) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      mask_r <= '0;
    end else begin
      st_r   <= st_nxt;
      s1_v_r <= s1_load;
      s2_v_r <= s1_v_r;
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= char_code;
      x0_r   <= pos_x;
      y0_r   <= pos_y;
      tbuf_r <= buffer_select;
    end
    if (st_r == ST_PREP) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        xcol_r[c] <= sx[c][DIM_BITS-1:0];
      end
      col_r <= '0;
      row_r <= '0;
    end else if (st_r == ST_WALK) begin
      if (row_r == 3'(GLYPH_ROWS - 1)) begin
        row_r <= '0;
        col_r <= col_r + 3'd1;
      end else begin
        row_r <= row_r + 3'd1;
      end
    end
    s1_wr_r    <= s1_wr_n;
    s1_last_r  <= s1_last_n;
    s1_x_r     <= s1_x_n;
    s1_y_r     <= s1_y_n;
    s1_buf_r   <= tbuf_r;
    s1_alpha_r <= text_alpha;
    s2_wr_r    <= s1_wr_r;
    s2_last_r  <= s1_last_r;
    s2_buf_r   <= s1_buf_r;
    s2_alpha_r <= s1_alpha_r;
    s2_x_r     <= s1_x_r;
    s2_prod_r  <= PW'(s1_y_r) * PW'(disp_width);
  end

  assign pix = {1'b0, s2_prod_r} + (PW+1)'(s2_x_r);

  always_comb begin
    push.valid       = s2_v_r;
    push.rec.last    = s2_last_r;
    push.rec.wr      = s2_wr_r;
    push.rec.buf_sel = s2_wr_r & s2_buf_r;
    push.rec.word    = s2_wr_r ? pix[WORD_BITS:1] : '0;
    push.rec.lane    = s2_wr_r & pix[0];
    push.rec.alpha   = s2_wr_r ? s2_alpha_r : '0;
  end

  `GAR_ASSERT(a_walk_mask, (st_r == ST_WALK) |-> (mask_r != '0), "walk with no pixels left")
  `GAR_ASSERT(a_end_rec_last, (s1_v_r && !s1_wr_r) |-> s1_last_r, "end record not marked last")
  `GAR_ASSERT_NEXT(a_accept_prep, in_valid && in_ready, st_r == ST_PREP, "accept without prep")

endmodule

### rtl/core/gar_outq.sv
`include "assert_macros.svh"

module gar_outq #(
  parameter int DEPTH = gar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gar_pkg::push_t  push,
  output logic            space_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output gar_pkg::res_t   out_rec
);

  import gar_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $bits(res_t);

  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          infl_r, out_v_r, skid_v_r;
  logic          out_v_nxt, skid_v_nxt;
  res_t          out_rec_r, skid_rec_r;
  logic [RW-1:0] ram_rdata;
  res_t          ram_rec;
  logic          take, out_free, issue;
  logic [1:0]    occ, occ_left;
  logic          load_out_skid, load_out_ram, load_skid_ram;

  gar_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (push.valid),
    .waddr(wr_ptr_r),
    .wdata(push.rec),
    .re   (issue),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  assign ram_rec  = res_t'(ram_rdata);
  assign take     = out_v_r && out_ready;
  assign out_free = !out_v_r || take;
  assign occ      = 2'(out_v_r) + 2'(skid_v_r) + 2'(infl_r);
  assign occ_left = occ - 2'(take);
  assign issue    = (cnt_r != '0) && (occ_left < 2'd2);
  assign space_ok = (cnt_r <= CW'(DEPTH - GLYPH_BITS));

  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    load_out_skid = 1'b0;
    load_out_ram  = 1'b0;
    load_skid_ram = 1'b0;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt     = 1'b1;
        load_out_skid = 1'b1;
        if (infl_r) begin
          load_skid_ram = 1'b1;
        end else begin
          skid_v_nxt = 1'b0;
        end
      end else if (infl_r) begin
        out_v_nxt    = 1'b1;
        load_out_ram = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (infl_r) begin
      skid_v_nxt    = 1'b1;
      load_skid_ram = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      infl_r   <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (issue) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r    <= cnt_r + CW'(push.valid) - CW'(issue);
      infl_r   <= issue;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      out_rec_r <= skid_rec_r;
    end else if (load_out_ram) begin
      out_rec_r <= ram_rec;
    end
    if (load_skid_ram) begin
      skid_rec_r <= ram_rec;
    end
  end

  assign out_valid = out_v_r;
  assign out_rec   = out_rec_r;

  `GAR_ASSERT(a_no_overflow, push.valid |-> (cnt_r != CW'(DEPTH)), "push into full queue")
  `GAR_ASSERT(a_occ_bound, occ <= 2'd2, "more reads in flight than slots")
  `GAR_ASSERT(a_skid_behind, skid_v_r |-> out_v_r, "skid holds data ahead of output")

endmodule

### dv/glyph_alpha_rasterizer_checker.sv
module glyph_alpha_rasterizer_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [31:0]                        in_tdata,
  input  logic                               in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [gar_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  input  logic [1:0]                         out_tuser,
  input  logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [gar_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  input  logic                               cfg_pready,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 chars_seen,
  output int                                 results_seen,
  output int                                 writes_seen
);
  import gar_pkg::*;

  localparam logic [7:0]  FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0]  LAST_PRINTABLE  = 8'd126;
  localparam logic        MIRROR_DEFAULT  = 1'b1;
  localparam logic [11:0] WIDTH_DEFAULT   = 12'd1080;
  localparam logic [11:0] HEIGHT_DEFAULT  = 12'd720;
  localparam logic [7:0]  ALPHA_DEFAULT   = 8'd255;
  localparam int          MAX_PIXELS      = 35;
  localparam int          REPORT_LIMIT    = 20;

  // column 0 in the top byte, bit r of a column is row r
  localparam logic [39:0] FONT [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  typedef struct packed {
    logic                  wr;
    logic                  tbuf;
    logic [WORD_BITS-1:0]  word;
    logic                  lane;
    logic [ALPHA_BITS-1:0] alpha;
    logic                  last;
  } alpha_write_t;

  logic        mirror_x;
  logic [11:0] disp_width;
  logic [11:0] disp_height;
  logic [7:0]  text_alpha;

  alpha_write_t pixel_writes_q[$];

  function automatic void rasterize_char(input logic [7:0] code, input logic signed [11:0] x0,
                                         input logic signed [11:0] y0, input logic sel);
    alpha_write_t hits [0:MAX_PIXELS-1];
    alpha_write_t item;
    logic [39:0]  cols;
    int           px;
    int           py;
    int           w;
    int           h;
    int           pix;
    int           n;
    int           c;
    int           r;
    w = disp_width;
    h = disp_height;
    n = 0;
    if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
      cols = FONT[code - FIRST_PRINTABLE];
      for (c = 0; c < 5; c++) begin
        for (r = 0; r < 7; r++) begin
          if (cols[32 - 8*c + r]) begin
            px = x0 + c;
            py = y0 + r;
            if (mirror_x) begin
              px = (w - 1) - px;
            end
            if (px >= 0 && px < w && py >= 0 && py < h) begin
              pix = py * w + px;
              item.wr = 1'b1;
              item.tbuf = sel;
              item.word = WORD_BITS'(pix >> 1);
              item.lane = pix[0];
              item.alpha = text_alpha;
              item.last = 1'b0;
              hits[n] = item;
              n++;
            end
          end
        end
      end
    end
    if (n == 0) begin
      item = '0;
      item.last = 1'b1;
      pixel_writes_q.push_back(item);
    end else begin
      hits[n-1].last = 1'b1;
      for (c = 0; c < n; c++) begin
        pixel_writes_q.push_back(hits[c]);
      end
    end
  endfunction

  function automatic void check_alpha_write();
    alpha_write_t got;
    alpha_write_t want;
    got.wr = out_tuser[0];
    got.tbuf = out_tuser[1];
    got.word = out_tdata[WORD_BITS-1:0];
    got.lane = out_tdata[WORD_BITS];
    got.alpha = out_tdata[WORD_BITS+1 +: ALPHA_BITS];
    got.last = out_tlast;
    results_seen++;
    if (got.wr === 1'b1) begin
      writes_seen++;
    end
    if (pixel_writes_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: unexpected result wr=%0b buf=%0b word=%0h lane=%0b alpha=%0h last=%0b",
                 $time, got.wr, got.tbuf, got.word, got.lane, got.alpha, got.last);
      end
    end else begin
      want = pixel_writes_q.pop_front();
      if (got.wr !== want.wr || got.tbuf !== want.tbuf || got.word !== want.word ||
          got.lane !== want.lane || got.alpha !== want.alpha || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result mismatch expected wr=%0b buf=%0b word=%0h lane=%0b alpha=%0h last=%0b",
                   $time, want.wr, want.tbuf, want.word, want.lane, want.alpha, want.last);
          $display("%0t:                   actual wr=%0b buf=%0b word=%0h lane=%0b alpha=%0h last=%0b",
                   $time, got.wr, got.tbuf, got.word, got.lane, got.alpha, got.last);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_x <= MIRROR_DEFAULT;
      disp_width <= WIDTH_DEFAULT;
      disp_height <= HEIGHT_DEFAULT;
      text_alpha <= ALPHA_DEFAULT;
      pixel_writes_q.delete();
      mismatches = 0;
      chars_seen = 0;
      results_seen = 0;
      writes_seen = 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_MIRROR: mirror_x <= cfg_pwdata[0];
          REG_WIDTH:  disp_width <= cfg_pwdata[11:0];
          REG_HEIGHT: disp_height <= cfg_pwdata[11:0];
          REG_ALPHA:  text_alpha <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        rasterize_char(in_tdata[7:0], in_tdata[19:8], in_tdata[31:20], in_tuser);
        chars_seen++;
      end
      if (out_tvalid && out_tready) begin
        check_alpha_write();
      end
      pending <= pixel_writes_q.size();
    end
  end

endmodule

### dv/glyph_alpha_rasterizer_tb.sv
module glyph_alpha_rasterizer_tb;
  import gar_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 60;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic [31:0]               in_tdata = '0;
  logic                      in_tuser = 1'b0;
  logic                      out_tready = 1'b0;
  logic                      cfg_psel = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_paddr = '0;
  logic [31:0]               cfg_pwdata = '0;

  logic                      in_tready;
  logic                      out_tvalid;
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic [1:0]                out_tuser;
  logic                      out_tlast;
  logic [31:0]               cfg_prdata;
  logic                      cfg_pready;

  int mismatches;
  int pending;
  int chars_seen;
  int results_seen;
  int writes_seen;

  int          cycles = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          stall_hold = 0;
  logic [11:0] width_now = 12'd1080;
  logic [11:0] height_now = 12'd720;

  glyph_alpha_rasterizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  glyph_alpha_rasterizer_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_pready   (cfg_pready),
    .mismatches   (mismatches),
    .pending      (pending),
    .chars_seen   (chars_seen),
    .results_seen (results_seen),
    .writes_seen  (writes_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[glyph_alpha_rasterizer] ERROR");
      $finish;
    end
  end

  // receiver: always ready, coin flip, two of three, or long stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= (cycles % 3 != 0);
      default: begin
        if (stall_hold == 0) begin
          out_tready <= ~out_tready;
          stall_hold <= out_tready ? $urandom_range(8, 30) : $urandom_range(1, 6);
        end else begin
          stall_hold <= stall_hold - 1;
        end
      end
    endcase
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic apply_settings(input logic m, input logic [11:0] w, input logic [11:0] h,
                                input logic [7:0] a);
    cfg_write(REG_MIRROR, {31'd0, m});
    cfg_write(REG_WIDTH, {20'd0, w});
    cfg_write(REG_HEIGHT, {20'd0, h});
    cfg_write(REG_ALPHA, {24'd0, a});
    width_now = w;
    height_now = h;
  endtask

  // hold valid across a burst, drop it for a random gap at burst end
  task automatic send_char(input logic [7:0] code, input logic [11:0] x, input logic [11:0] y,
                           input logic sel);
    in_tvalid <= 1'b1;
    in_tdata <= {y, x, code};
    in_tuser <= sel;
    do @(posedge clk); while (!in_tready);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_writes();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [11:0] near_coord(input int span);
    int v;
    if ($urandom_range(0, 9) < 8) begin
      v = $urandom_range(0, span + 10) - 8;
      if (v > 2047) begin
        v = 2047;
      end
      return v[11:0];
    end
    return 12'($urandom);
  endfunction

  task automatic random_chars(input int n);
    logic [7:0]  code;
    logic [11:0] x;
    logic [11:0] y;
    repeat (n) begin
      code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
      x = near_coord(width_now);
      y = near_coord(height_now);
      send_char(code, x, y, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: mirrored, 1080 x 720, full alpha
    send_char(8'd0, 12'd0, 12'd0, 1'b0);
    send_char(8'd31, 12'd5, 12'd5, 1'b1);
    send_char(8'd127, 12'd100, 12'd100, 1'b1);
    send_char(8'd255, 12'h800, 12'h7FF, 1'b1);
    send_char(8'h20, 12'd10, 12'd10, 1'b0);
    send_char(8'h21, 12'd0, 12'd0, 1'b1);
    send_char(8'h7E, 12'd500, 12'd300, 1'b0);
    send_char(8'h41, 12'd1078, 12'd0, 1'b1);
    send_char(8'h23, -12'sd2, 12'd716, 1'b0);
    send_char(8'h4D, 12'h7FF, 12'h7FF, 1'b1);
    send_char(8'h57, 12'h800, 12'h800, 1'b0);
    send_char(8'h40, 12'd1075, -12'sd3, 1'b1);
    send_char(8'h42, 12'd1077, 12'd717, 1'b0);
    send_char(8'h67, 12'd537, 12'd359, 1'b1);
    send_char(8'h38, 12'hFFF, 12'hFFF, 1'b1);
    drain_writes();

    apply_settings(1'b0, 12'd1080, 12'd720, 8'h5A);
    send_char(8'h23, -12'sd2, -12'sd3, 1'b1);
    send_char(8'h40, 12'd1077, 12'd716, 1'b0);
    random_chars(78);
    drain_writes();

    apply_settings(1'b1, 12'd1, 12'd1, 8'h00);
    random_chars(40);
    drain_writes();

    // zero width and height: nothing fits
    apply_settings(1'b0, 12'd0, 12'd0, 8'hA5);
    random_chars(15);
    drain_writes();

    // index overflows the word field and wraps
    apply_settings(1'b1, 12'd4095, 12'd4095, 8'hFF);
    send_char(8'h40, -12'sd4, 12'd2047, 1'b1);
    random_chars(59);
    drain_writes();

    apply_settings(1'b0, 12'd13, 12'd9, 8'($urandom));
    random_chars(60);
    drain_writes();

    apply_settings(1'($urandom), 12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)),
                   8'($urandom));
    random_chars(50);
    drain_writes();

    apply_settings(1'($urandom), 12'($urandom_range(1, 64)), 12'($urandom_range(1, 64)),
                   8'($urandom));
    random_chars(50);
    drain_writes();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d characters giving %0d results, %0d of them pixel writes",
             chars_seen, results_seen, writes_seen);
    $display("settings: reset, plain and mirrored, 1x1, zero size, wrapping 4095 wide, random");
    if (mismatches == 0 && pending == 0) begin
      $display("[glyph_alpha_rasterizer] OK");
    end else begin
      $display("[glyph_alpha_rasterizer] ERROR");
    end
    $finish;
  end

endmodule
